// ----- hw/rtl/psm_pkg.sv -----
package psm_pkg;

    // widths fixed by the request format
    localparam int IDX_W    = 4;
    localparam int START_W  = 16;
    localparam int FRAMES_W = 17;
    localparam int CUR_W    = 17;
    localparam int CHAN_W   = 2;
    localparam int ACT_W    = 2;
    localparam int PADDR_W  = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_SAMPLE  = 2'd0,
        ACT_DEFINE  = 2'd1,
        ACT_TRIGGER = 2'd2,
        ACT_TICK    = 2'd3
    } t_action;

endpackage

// ----- hw/rtl/polyphonic_sample_mixer.sv -----
// Polyphonic sample mixer. Each request either writes one stereo frame into the sample
// memory, defines a sound (start frame, frame count, channel count; a frame count of zero
// leaves it undefined), starts a voice of a defined sound at frame 0, or ticks one output
// frame. Sample writes, sound definitions and voice starts never stall the request port.
// A tick walks the voice list held in a single-port-read voice memory, one voice per
// cycle, including voices that end and are replaced by the last one in the list. After
// the walk, a drain state lets the sample memory read of the last voice reach the sums,
// and a done state loads the result into the output register once that register is free;
// the request channel reopens in the cycle after the result is loaded there. A result
// waiting in the output register does not block the next request. Channel sums are exact
// and saturate to the sample width, raising o_clipped; in mono mode (out_channels = 1)
// the right output is zero. Sounds with more channels than out_channels stay silent and
// never end. Sample memory and voice memory are not cleared by reset: reading a sample
// frame never written gives undefined data. SAMPLE_DEPTH must be a power of two.
module polyphonic_sample_mixer
    import psm_pkg::*;
#(
    parameter int NUM_SOUNDS   = 16,
    parameter int MAX_VOICES   = 32,
    parameter int SAMPLE_DEPTH = 65536,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [CHAN_W-1:0]                    i_cfg_data,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [ACT_W-1:0]                     i_action,
    input  logic [IDX_W-1:0]                     i_sound_index,
    input  logic [PADDR_W-1:0]                   i_sample_address,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_left,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_right,
    input  logic [START_W-1:0]                   i_sound_start,
    input  logic [FRAMES_W-1:0]                  i_sound_frames,
    input  logic [CHAN_W-1:0]                    i_sound_channel_count,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]        o_out_left,
    output logic signed [SAMPLE_BITS-1:0]        o_out_right,
    output logic                                 o_clipped,
    output logic [$clog2(MAX_VOICES+1)-1:0]      o_active_voices
);

    // sound index, voice slot and voice count widths
    localparam int SW     = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
    localparam int NSW    = $clog2(NUM_SOUNDS + 1);
    localparam int IW     = (NSW > IDX_W) ? NSW : IDX_W;
    localparam int VW     = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CW     = $clog2(MAX_VOICES + 1);
    // sample memory addressing
    localparam int AW     = $clog2(SAMPLE_DEPTH);
    localparam int WA_W   = (AW > PADDR_W) ? AW : PADDR_W;
    localparam int RA_W   = (AW > CUR_W + 1) ? AW : CUR_W + 1;
    // mix accumulator, wide enough for every voice at full scale
    localparam int ACC_W  = SAMPLE_BITS + $clog2(MAX_VOICES + 1);
    localparam int VOICE_W = SW + CUR_W;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DRAIN,
        S_DONE
    } t_state;

    // control state
    t_state                       r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [CW-1:0]                r_slot, n_slot;
    logic [CHAN_W-1:0]            r_out_ch;
    logic [1:0]                   r_acc_mask;
    logic                         r_out_valid;

    // sound table in flops: lengths and channel counts reset, start does not
    logic [START_W-1:0]           r_snd_start [NUM_SOUNDS];
    logic [FRAMES_W-1:0]          r_snd_len   [NUM_SOUNDS];
    logic [CHAN_W-1:0]            r_snd_chan  [NUM_SOUNDS];

    // voice memory: {sound, cursor} per slot
    logic [VOICE_W-1:0]           voice_mem [MAX_VOICES];
    logic [VOICE_W-1:0]           r_vq;
    logic                         vm_we;
    logic [VW-1:0]                vm_waddr;
    logic [VOICE_W-1:0]           vm_wdata;
    logic [VW-1:0]                vm_raddr;

    // sample memory: {right, left} per frame
    logic [2*SAMPLE_BITS-1:0]     sample_mem [SAMPLE_DEPTH];
    logic [2*SAMPLE_BITS-1:0]     r_smp_q;
    logic                         sm_we;
    logic [AW-1:0]                sm_waddr;
    logic [AW-1:0]                sm_raddr;

    // mix sums and result
    logic signed [ACC_W-1:0]      r_sum_l, r_sum_r;
    logic signed [SAMPLE_BITS-1:0] r_out_left, r_out_right;
    logic                         r_clipped;
    logic [CW-1:0]                r_out_voices;

    // request decode
    logic                         in_accept;
    t_action                      act;
    logic [IW-1:0]                idx_ext;
    logic                         idx_ok;
    logic [SW-1:0]                idx;
    logic [WA_W-1:0]              waddr_ext;

    // voice evaluation
    logic [SW-1:0]                v_snd;
    logic [CUR_W-1:0]             v_cur, v_new_cur;
    logic [FRAMES_W-1:0]          v_len;
    logic [CHAN_W-1:0]            v_chan;
    logic                         v_playable, v_live, v_ended;
    logic [1:0]                   v_mask;
    logic [RA_W-1:0]              raddr_sum;
    logic [CW-1:0]                cnt_less;
    logic [CW-1:0]                slot_inc;

    // saturation
    logic signed [ACC_W-1:0]      sat_l, sat_r;
    logic                         clip_l, clip_r;
    logic                         out_free;

    assign o_in_stall      = (r_state != S_IDLE);
    assign in_accept       = i_in_valid && !o_in_stall;
    assign act             = t_action'(i_action);
    assign idx_ext         = IW'(i_sound_index);
    assign idx_ok          = idx_ext < IW'(NUM_SOUNDS);
    assign idx             = idx_ext[SW-1:0];
    assign waddr_ext       = WA_W'(i_sample_address);

    assign o_out_valid     = r_out_valid;
    assign o_out_left      = r_out_left;
    assign o_out_right     = r_out_right;
    assign o_clipped       = r_clipped;
    assign o_active_voices = r_out_voices;
    assign out_free        = !r_out_valid || !i_out_stall;

    // current voice, read last cycle
    always_comb begin
        v_snd      = r_vq[VOICE_W-1:CUR_W];
        v_cur      = r_vq[CUR_W-1:0];
        v_len      = r_snd_len[v_snd];
        v_chan     = r_snd_chan[v_snd];
        v_playable = v_chan <= r_out_ch;
        v_live     = v_playable && (FRAMES_W'(v_cur) < v_len);
        v_new_cur  = v_live ? v_cur + CUR_W'(1) : v_cur;
        v_ended    = v_playable && (FRAMES_W'(v_new_cur) >= v_len);
        v_mask[0]  = v_live && (v_chan >= CHAN_W'(1)) && (r_out_ch >= CHAN_W'(1));
        v_mask[1]  = v_live && (v_chan >= CHAN_W'(2)) && (r_out_ch >= CHAN_W'(2));
        raddr_sum  = RA_W'(r_snd_start[v_snd]) + RA_W'(v_cur);
        cnt_less   = r_count - CW'(1);
        slot_inc   = r_slot + CW'(1);
    end

    assign sm_raddr = raddr_sum[AW-1:0];
    assign sm_waddr = waddr_ext[AW-1:0];
    assign sm_we    = in_accept && (act == ACT_SAMPLE);

    // sequencer: next state, voice memory ports
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_slot   = r_slot;
        vm_we    = 1'b0;
        vm_waddr = r_slot[VW-1:0];
        vm_wdata = {v_snd, v_new_cur};
        vm_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (act)
                        ACT_TRIGGER: begin
                            if (idx_ok && (r_snd_len[idx] != '0) &&
                                (r_count < CW'(MAX_VOICES))) begin
                                vm_we    = 1'b1;
                                vm_waddr = r_count[VW-1:0];
                                vm_wdata = {idx, CUR_W'(0)};
                                n_count  = r_count + CW'(1);
                            end
                        end
                        ACT_TICK: begin
                            n_slot  = '0;
                            n_state = (r_count != '0) ? S_EVAL : S_DRAIN;
                        end
                        default: ;
                    endcase
                end
            end
            S_EVAL: begin
                if (v_ended) begin
                    // swap the last voice into this slot and visit it next
                    n_count  = cnt_less;
                    vm_raddr = cnt_less[VW-1:0];
                    if (r_slot >= cnt_less) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    vm_we    = 1'b1;
                    n_slot   = slot_inc;
                    vm_raddr = slot_inc[VW-1:0];
                    if (slot_inc >= r_count) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // saturate the finished sums
    always_comb begin
        clip_l = 1'b0;
        clip_r = 1'b0;
        sat_l  = '0;
        sat_r  = '0;
        if (r_out_ch >= CHAN_W'(1)) begin
            if (r_sum_l > SAT_HI) begin
                sat_l  = SAT_HI;
                clip_l = 1'b1;
            end else if (r_sum_l < SAT_LO) begin
                sat_l  = SAT_LO;
                clip_l = 1'b1;
            end else begin
                sat_l  = r_sum_l;
            end
        end
        if (r_out_ch >= CHAN_W'(2)) begin
            if (r_sum_r > SAT_HI) begin
                sat_r  = SAT_HI;
                clip_r = 1'b1;
            end else if (r_sum_r < SAT_LO) begin
                sat_r  = SAT_LO;
                clip_r = 1'b1;
            end else begin
                sat_r  = r_sum_r;
            end
        end
    end

    // voice memory
    always_ff @(posedge i_clk) begin
        if (vm_we) begin
            voice_mem[vm_waddr] <= vm_wdata;
        end
        r_vq <= voice_mem[vm_raddr];
    end

    // sample memory
    always_ff @(posedge i_clk) begin
        if (sm_we) begin
            sample_mem[sm_waddr] <= {i_sample_right, i_sample_left};
        end
        r_smp_q <= sample_mem[sm_raddr];
    end

    // sound table start addresses, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept && (act == ACT_DEFINE) && idx_ok) begin
            r_snd_start[idx] <= i_sound_start;
        end
    end

    // mix accumulator and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept && (act == ACT_TICK)) begin
            r_sum_l <= '0;
            r_sum_r <= '0;
        end else begin
            if (r_acc_mask[0]) begin
                r_sum_l <= r_sum_l + {{(ACC_W-SAMPLE_BITS){r_smp_q[SAMPLE_BITS-1]}},
                                      r_smp_q[SAMPLE_BITS-1:0]};
            end
            if (r_acc_mask[1]) begin
                r_sum_r <= r_sum_r + {{(ACC_W-SAMPLE_BITS){r_smp_q[2*SAMPLE_BITS-1]}},
                                      r_smp_q[2*SAMPLE_BITS-1:SAMPLE_BITS]};
            end
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_left   <= sat_l[SAMPLE_BITS-1:0];
            r_out_right  <= sat_r[SAMPLE_BITS-1:0];
            r_clipped    <= clip_l || clip_r;
            // voice count held with the frame, later triggers do not disturb it
            r_out_voices <= r_count;
        end
    end

    // control state, sound lengths and channel counts, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_slot      <= '0;
            r_out_ch    <= CHAN_W'(2);
            r_acc_mask  <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < NUM_SOUNDS; s++) begin
                r_snd_len[s]  <= '0;
                r_snd_chan[s] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_slot     <= n_slot;
            r_acc_mask <= (r_state == S_EVAL) ? v_mask : 2'b00;
            if (i_cfg_we) begin
                r_out_ch <= i_cfg_data;
            end
            if (in_accept && (act == ACT_DEFINE) && idx_ok) begin
                r_snd_len[idx]  <= i_sound_frames;
                r_snd_chan[idx] <= i_sound_channel_count;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VOICES))
        else $error("voice count beyond capacity");

    a_slot_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_slot < r_count))
        else $error("voice walk past end of list");

    a_tick_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |=> (r_count <= $past(r_count)))
        else $error("voice count grew during a tick");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (act == ACT_TICK)) |=> o_in_stall)
        else $error("request taken while a tick is in progress");

endmodule

// ----- tb/polyphonic_sample_mixer_tb.sv -----
module polyphonic_sample_mixer_tb;
    import psm_pkg::*;

    localparam int NUM_SOUNDS     = 16;
    localparam int MAX_VOICES     = 32;
    localparam int SAMPLE_DEPTH   = 65536;
    localparam int SAMPLE_BITS    = 16;
    localparam int VOICE_W        = $clog2(MAX_VOICES + 1);
    localparam int SAMPLE_MAX     = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int SAMPLE_MIN     = -SAMPLE_MAX - 1;
    // room for the longest tick: a walk over every voice and the memory reads after it
    localparam int SETTLE_CYCLES  = MAX_VOICES + 16;
    localparam int WATCHDOG_LIMIT = 4000;

    // one request as it sits on the request ports
    typedef struct packed {
        t_action                       act;
        logic [IDX_W-1:0]              idx;
        logic [PADDR_W-1:0]            addr;
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic [START_W-1:0]            start;
        logic [FRAMES_W-1:0]           frames;
        logic [CHAN_W-1:0]             chans;
    } t_mix_request;

    // one mixed output frame
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic                          clip;
        logic [VOICE_W-1:0]            voices;
    } t_mix_frame;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_LONG
    } t_stall_mode;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [CHAN_W-1:0]             cfg_data = 2'd2;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    t_mix_request                  cur_request = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic                          out_clip;
    logic [VOICE_W-1:0]            out_voices;

    polyphonic_sample_mixer #(
        .NUM_SOUNDS   (NUM_SOUNDS),
        .MAX_VOICES   (MAX_VOICES),
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) uut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_we              (cfg_we),
        .i_cfg_data            (cfg_data),
        .i_in_valid            (in_valid),
        .o_in_stall            (in_stall),
        .i_action              (cur_request.act),
        .i_sound_index         (cur_request.idx),
        .i_sample_address      (cur_request.addr),
        .i_sample_left         (cur_request.left),
        .i_sample_right        (cur_request.right),
        .i_sound_start         (cur_request.start),
        .i_sound_frames        (cur_request.frames),
        .i_sound_channel_count (cur_request.chans),
        .o_out_valid           (out_valid),
        .i_out_stall           (out_stall),
        .o_out_left            (out_left),
        .o_out_right           (out_right),
        .o_clipped             (out_clip),
        .o_active_voices       (out_voices)
    );

    // 8 unit period, high then low
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // mixer predictor: its own copy of sample memory, sound table, voices
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] pcm_left  [SAMPLE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] pcm_right [SAMPLE_DEPTH];
    bit                            pcm_written [SAMPLE_DEPTH];
    int                            sound_base  [NUM_SOUNDS];
    int                            sound_len   [NUM_SOUNDS];
    int                            sound_chans [NUM_SOUNDS];
    int                            voice_sound_of [MAX_VOICES];
    int                            voice_pos      [MAX_VOICES];
    int                            voices_playing = 0;
    int                            out_chans = 2;
    t_mix_frame                    expected_frames [$];

    // run statistics and failure count
    int errors = 0;
    int requests_accepted = 0;
    int frames_checked = 0;
    int clipped_frames = 0;
    int triggers_refused = 0;
    int peak_voices = 0;
    int config_writes = 0;

    // frame address a voice reads on the next tick, or -1 if it stays silent
    // (too many channels for the output, or already past its sound's end)
    function automatic int voice_frame_addr(input int v);
        int s;
        s = voice_sound_of[v];
        if (sound_chans[s] > out_chans || voice_pos[v] >= sound_len[s])
            return -1;
        return (sound_base[s] + voice_pos[v]) % SAMPLE_DEPTH;
    endfunction

    function automatic bit clamp_sample(input int total,
                                        output logic signed [SAMPLE_BITS-1:0] clamped);
        if (total > SAMPLE_MAX) begin
            clamped = SAMPLE_BITS'(SAMPLE_MAX);
            return 1'b1;
        end
        if (total < SAMPLE_MIN) begin
            clamped = SAMPLE_BITS'(SAMPLE_MIN);
            return 1'b1;
        end
        clamped = total[SAMPLE_BITS-1:0];
        return 1'b0;
    endfunction

    // applies one accepted request; a tick queues the frame it must produce
    function automatic void advance_mixer(input t_mix_request rq);
        int sum_l, sum_r, v, s, a;
        bit clip_l, clip_r;
        logic signed [SAMPLE_BITS-1:0] mix_l, mix_r;
        t_mix_frame fr;
        case (rq.act)
            ACT_SAMPLE: begin
                pcm_left[rq.addr]    = rq.left;
                pcm_right[rq.addr]   = rq.right;
                pcm_written[rq.addr] = 1'b1;
            end
            ACT_DEFINE: begin
                sound_base[rq.idx]  = int'(rq.start);
                sound_len[rq.idx]   = int'(rq.frames);
                sound_chans[rq.idx] = int'(rq.chans);
            end
            ACT_TRIGGER: begin
                if (sound_len[rq.idx] != 0 && voices_playing < MAX_VOICES) begin
                    voice_sound_of[voices_playing] = int'(rq.idx);
                    voice_pos[voices_playing]      = 0;
                    voices_playing++;
                    if (voices_playing > peak_voices)
                        peak_voices = voices_playing;
                end else if (sound_len[rq.idx] != 0) begin
                    triggers_refused++;
                end
            end
            default: begin
                sum_l = 0;
                sum_r = 0;
                for (v = 0; v < voices_playing; v++) begin
                    a = voice_frame_addr(v);
                    if (a >= 0) begin
                        s = voice_sound_of[v];
                        if (sound_chans[s] >= 1 && out_chans >= 1)
                            sum_l += pcm_left[a];
                        if (sound_chans[s] >= 2 && out_chans >= 2)
                            sum_r += pcm_right[a];
                        voice_pos[v]++;
                    end
                end
                // ended voices make way for the last one in the list
                v = 0;
                while (v < voices_playing) begin
                    s = voice_sound_of[v];
                    if (sound_chans[s] <= out_chans && voice_pos[v] >= sound_len[s]) begin
                        voices_playing--;
                        voice_sound_of[v] = voice_sound_of[voices_playing];
                        voice_pos[v]      = voice_pos[voices_playing];
                    end else begin
                        v++;
                    end
                end
                clip_l = 1'b0;
                clip_r = 1'b0;
                mix_l  = '0;
                mix_r  = '0;
                if (out_chans >= 1)
                    clip_l = clamp_sample(sum_l, mix_l);
                if (out_chans >= 2)
                    clip_r = clamp_sample(sum_r, mix_r);
                fr.left   = mix_l;
                fr.right  = mix_r;
                fr.clip   = clip_l | clip_r;
                fr.voices = VOICE_W'(voices_playing);
                expected_frames = {expected_frames, fr};
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // request driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    bit           request_pending = 1'b0;
    t_mix_request pending_request = '0;
    event         request_taken;
    int           burst_left = 0;
    int           gap_left = 0;

    always @(negedge clk) begin
        if (gap_left > 0) begin
            in_valid <= 1'b0;
            gap_left--;
        end else if (request_pending) begin
            cur_request <= pending_request;
            in_valid    <= 1'b1;
        end else begin
            in_valid <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            request_pending = 1'b0;
            advance_mixer(cur_request);
            requests_accepted++;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                // a quarter of the bursts run straight on with no gap
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            -> request_taken;
        end
    end

    task automatic send_request(input t_mix_request rq);
        pending_request = rq;
        request_pending = 1'b1;
        @(request_taken);
    endtask

    // ------------------------------------------------------------------
    // result side: own stall pattern, field-by-field comparison
    // ------------------------------------------------------------------
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;

    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: out_stall <= (stall_left % 5) < 3;
            default:        out_stall <= (stall_left % 32) >= 12;
        endcase
    end

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk) begin : frame_check
        t_mix_frame want;
        if (rst_n && out_valid && !out_stall) begin
            frames_checked++;
            if (out_clip)
                clipped_frames++;
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected frame, expected none, got left %0d right %0d",
                         $time, out_left, out_right);
                errors++;
            end else begin
                want = expected_frames.pop_front();
                check_field("out_left", int'($signed(want.left)), int'(out_left));
                check_field("out_right", int'($signed(want.right)), int'(out_right));
                check_field("clipped", int'(want.clip), int'(out_clip));
                check_field("active_voices", int'(want.voices), int'(out_voices));
            end
        end
    end

    // gives up when neither channel has moved for too long
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d frames still owed",
                     $time, quiet_cycles, expected_frames.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // request builders
    // ------------------------------------------------------------------
    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        logic [31:0] r;
        r = $urandom;
        case (r[2:0])
            3'd0:    return SAMPLE_BITS'(SAMPLE_MAX);
            3'd1:    return SAMPLE_BITS'(SAMPLE_MIN);
            3'd2:    return SAMPLE_BITS'($signed(r[15:8]));
            default: return r[31:16];
        endcase
    endfunction

    // every field random, so idle fields still toggle; callers override
    function automatic t_mix_request random_request(input t_action act);
        t_mix_request rq;
        logic [31:0] r0, r1, r2;
        r0 = $urandom;
        r1 = $urandom;
        r2 = $urandom;
        rq.act    = act;
        rq.idx    = r0[IDX_W-1:0];
        rq.addr   = r0[31:16];
        rq.left   = r1[15:0];
        rq.right  = r1[31:16];
        rq.start  = r2[15:0];
        rq.frames = FRAMES_W'($urandom_range(0, SAMPLE_DEPTH));
        rq.chans  = r2[17:16];
        return rq;
    endfunction

    task automatic write_frame(input int addr, input logic signed [SAMPLE_BITS-1:0] l,
                               input logic signed [SAMPLE_BITS-1:0] r);
        t_mix_request rq;
        rq       = random_request(ACT_SAMPLE);
        rq.addr  = PADDR_W'(addr);
        rq.left  = l;
        rq.right = r;
        send_request(rq);
    endtask

    task automatic define_sound(input int idx, input int base, input int frames,
                                input int chans);
        t_mix_request rq;
        rq        = random_request(ACT_DEFINE);
        rq.idx    = IDX_W'(idx);
        rq.start  = START_W'(base);
        rq.frames = FRAMES_W'(frames);
        rq.chans  = CHAN_W'(chans);
        send_request(rq);
    endtask

    task automatic trigger_voice(input int idx);
        t_mix_request rq;
        rq     = random_request(ACT_TRIGGER);
        rq.idx = IDX_W'(idx);
        send_request(rq);
    endtask

    // a voice must never read a frame that was never written, so any
    // such frame gets random content just before the tick
    task automatic tick_frame();
        int v, a;
        for (v = 0; v < voices_playing; v++) begin
            a = voice_frame_addr(v);
            if (a >= 0 && !pcm_written[a])
                write_frame(a, random_sample(), random_sample());
        end
        send_request(random_request(ACT_TICK));
    endtask

    // waits out every owed frame, then the longest tick
    task automatic drain_results();
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_out_channels(input int chans);
        drain_results();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= chans[CHAN_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        out_chans = chans;
        config_writes++;
    endtask

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // sample extremes at both ends of memory, then a tick with nothing playing
    task automatic test_empty_tick();
        write_frame(0, SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MIN));
        write_frame(SAMPLE_DEPTH - 1, SAMPLE_BITS'(SAMPLE_MIN), SAMPLE_BITS'(SAMPLE_MAX));
        tick_frame();
    endtask

    // sound starting on the last frame wraps round to frame 0
    task automatic test_wrapping_sound();
        define_sound(NUM_SOUNDS - 1, SAMPLE_DEPTH - 1, 2, 2);
        trigger_voice(NUM_SOUNDS - 1);
        tick_frame();
        tick_frame();
    endtask

    // zero-length and never-defined sounds refuse a trigger
    task automatic test_undefined_sound();
        define_sound(0, 0, 0, 1);
        trigger_voice(0);
        trigger_voice(9);
        tick_frame();
    endtask

    // silent zero-channel sound still ends; an over-wide sound hangs until
    // it is redefined narrower
    task automatic test_channel_counts();
        define_sound(4, 0, 2, 0);
        define_sound(5, 0, 1, 3);
        trigger_voice(4);
        trigger_voice(5);
        tick_frame();
        tick_frame();
        define_sound(5, 0, 1, 1);
        tick_frame();
    endtask

    // two full-scale voices clip high, two at the floor clip low
    task automatic test_saturation();
        write_frame(100, SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MAX));
        write_frame(101, SAMPLE_BITS'(SAMPLE_MIN), SAMPLE_BITS'(SAMPLE_MIN));
        define_sound(1, 100, 1, 2);
        define_sound(2, 101, 1, 2);
        trigger_voice(1);
        trigger_voice(1);
        tick_frame();
        trigger_voice(2);
        trigger_voice(2);
        tick_frame();
    endtask

    // mono: right stays zero and a stereo voice waits for stereo output
    task automatic test_mono_mode();
        define_sound(6, 100, 1, 1);
        set_out_channels(1);
        trigger_voice(1);
        trigger_voice(6);
        trigger_voice(6);
        tick_frame();
        set_out_channels(2);
        tick_frame();
    endtask

    // ------------------------------------------------------------------
    // random traffic: mostly phrases (load, define, trigger, play),
    // with voice pile-ups, loose noise requests and full drains mixed in
    // ------------------------------------------------------------------
    task automatic test_random_traffic(input int budget);
        int stop_at, n, k, idx, len, base, chans;
        t_mix_request rq;
        stop_at = requests_accepted + budget;
        while (requests_accepted < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    idx   = $urandom_range(0, NUM_SOUNDS - 1);
                    len   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                        : $urandom_range(1, 8);
                    base  = $urandom_range(0, SAMPLE_DEPTH - 1);
                    chans = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3)
                                                        : $urandom_range(1, out_chans);
                    for (k = 0; k < len && k < 8; k++)
                        write_frame((base + k) % SAMPLE_DEPTH, random_sample(),
                                    random_sample());
                    define_sound(idx, base, len, chans);
                    n = $urandom_range(1, 4);
                    repeat (n) trigger_voice(idx);
                    n = $urandom_range(1, len + 2);
                    repeat (n) begin
                        if ($urandom_range(0, 5) == 0)
                            trigger_voice($urandom_range(0, NUM_SOUNDS - 1));
                        tick_frame();
                    end
                end
                6: begin
                    // pile-up, often enough to fill the voice list
                    n = $urandom_range(8, 40);
                    repeat (n) trigger_voice($urandom_range(0, NUM_SOUNDS - 1));
                    n = $urandom_range(1, 4);
                    repeat (n) tick_frame();
                end
                7, 8: begin
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        rq = random_request(t_action'($urandom_range(0, 3)));
                        case (rq.act)
                            ACT_TICK: tick_frame();
                            ACT_DEFINE: begin
                                case ($urandom_range(0, 9))
                                    0:       rq.frames = FRAMES_W'(SAMPLE_DEPTH);
                                    1, 2:    rq.frames = FRAMES_W'($urandom_range(0,
                                                                   SAMPLE_DEPTH));
                                    default: rq.frames = FRAMES_W'($urandom_range(0, 15));
                                endcase
                                send_request(rq);
                            end
                            default: send_request(rq);
                        endcase
                    end
                end
                default: drain_results();
            endcase
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_tick();
        test_wrapping_sound();
        test_undefined_sound();
        test_channel_counts();
        test_saturation();
        test_mono_mode();

        set_out_channels(2);
        test_random_traffic(250);
        set_out_channels(1);
        test_random_traffic(250);
        set_out_channels(2);
        test_random_traffic(250);
        set_out_channels(1);
        test_random_traffic(150);
        set_out_channels(2);
        test_random_traffic(100);

        drain_results();
        $display("%0d requests, %0d frames compared (%0d clipped), %0d channel-mode writes",
                 requests_accepted, frames_checked, clipped_frames, config_writes);
        $display("voice list peaked at %0d of %0d, %0d triggers turned away when full",
                 peak_voices, MAX_VOICES, triggers_refused);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
